[design/fault_code_log_table_macros.svh]
// Assertion macros for the fault code log table.
`ifndef FAULT_CODE_LOG_TABLE_MACROS_SVH
`define FAULT_CODE_LOG_TABLE_MACROS_SVH

`ifndef ASSERT_OFF
`define FCLT_ASSERT(name, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("fault log assertion failed");
`define FCLT_ASSERT_NEVER(name, expr) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("fault log forbidden condition");
`else
`define FCLT_ASSERT(name, prop)
`define FCLT_ASSERT_NEVER(name, expr)
`endif

`endif

[design/fclt_pkg.sv]
// Shared constants and types of the fault code log table.
package fclt_pkg;

  localparam int MAX_ENTRIES = 16;
  localparam int IDX_W = $clog2(MAX_ENTRIES);
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam logic [7:0] OCC_MAX = 8'hFF;

  typedef enum logic [1:0] {
    CMD_LOG   = 2'd0,
    CMD_CLEAR = 2'd1,
    CMD_READ  = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_UPD,
    S_APPEND,
    S_RDWAIT,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [15:0] code;
    logic [7:0]  severity;
    logic [7:0]  occurrences;
    logic [31:0] first_seen;
    logic [31:0] last_seen;
    logic [31:0] context_word;
  } entry_t;

  typedef struct packed {
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
  } mem_req_t;

endpackage

[design/fclt_store.sv]
// Entry memory of the fault code log table, one read and one write port.
module fclt_store (
  input  logic              clk,
  input  fclt_pkg::mem_req_t req,
  input  fclt_pkg::entry_t   wr_data,
  output fclt_pkg::entry_t   rd_data
);

  fclt_pkg::entry_t mem [fclt_pkg::MAX_ENTRIES];
  fclt_pkg::entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data_r <= mem[req.rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[design/fault_code_log_table.sv]
// Fault code log table top level: ring-ordered entry memory with scan control.
// A log command scans the stored entries, one entry per cycle through the read port,
// then updates a repeat code in place or appends a new one; a read passes S_RDWAIT and
// a clear goes to S_DONE. busy falls in the strobe cycle, so commands do not overlap.
// Synchronous active-low reset empties the table; no memory clearing pass is needed.
// The receiver cannot stall: out_valid is a one-cycle strobe.
`include "fault_code_log_table_macros.svh"

module fault_code_log_table (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_cmd,
  input  logic [15:0] in_fault_code,
  input  logic [7:0]  in_fault_severity,
  input  logic [31:0] in_fault_context,
  input  logic [31:0] in_uptime_seconds,
  input  logic [3:0]  in_read_index,
  output logic        out_valid,
  output logic        out_new_fault_notify,
  output logic [4:0]  out_entry_count,
  output logic [15:0] out_newest_code,
  output logic        out_read_valid,
  output logic [15:0] out_read_code,
  output logic [7:0]  out_read_severity,
  output logic [7:0]  out_read_occurrences,
  output logic [31:0] out_read_first_seen,
  output logic [31:0] out_read_last_seen,
  output logic [31:0] out_read_context
);

  localparam int IW = fclt_pkg::IDX_W;
  localparam int CW = fclt_pkg::CNT_W;

  function automatic logic [IW-1:0] wrap_add(input logic [IW-1:0] base,
                                             input logic [IW-1:0] off);
    logic [IW:0] s;
    s = {1'b0, base} + {1'b0, off};
    if (s >= (IW+1)'(fclt_pkg::MAX_ENTRIES)) begin
      s = s - (IW+1)'(fclt_pkg::MAX_ENTRIES);
    end
    return s[IW-1:0];
  endfunction

  fclt_pkg::state_t   state_r, state_nxt;
  logic [CW-1:0]      count_r, count_nxt;
  logic [IW-1:0]      head_r, head_nxt;
  logic [15:0]        newest_r, newest_nxt;
  logic               out_valid_r, out_valid_nxt;

  logic [1:0]         cmd_r, cmd_nxt;
  logic [15:0]        code_r, code_nxt;
  logic [7:0]         sev_r, sev_nxt;
  logic [31:0]        ctx_r, ctx_nxt;
  logic [31:0]        now_r, now_nxt;
  logic [CW-1:0]      iss_r, iss_nxt;
  logic               chk_vld_r, chk_vld_nxt;
  logic [CW-1:0]      chk_idx_r, chk_idx_nxt;
  logic [IW-1:0]      match_addr_r, match_addr_nxt;
  logic               notify_r, notify_nxt;
  logic               rvalid_r, rvalid_nxt;
  fclt_pkg::entry_t   rsel_r, rsel_nxt;

  logic               out_notify_r, out_notify_nxt;
  logic [4:0]         out_count_r, out_count_nxt;
  logic [15:0]        out_newest_r, out_newest_nxt;
  logic               out_rvalid_r, out_rvalid_nxt;
  fclt_pkg::entry_t   out_entry_r, out_entry_nxt;

  fclt_pkg::mem_req_t mreq;
  fclt_pkg::entry_t   wr_data;
  fclt_pkg::entry_t   rd_data;

  logic               accept;
  logic               hit;
  logic               more;
  logic               full;
  logic               read_ok;

  fclt_store u_store (
    .clk     (clk),
    .req     (mreq),
    .wr_data (wr_data),
    .rd_data (rd_data)
  );

  assign accept  = start && (state_r == fclt_pkg::S_IDLE);
  assign hit     = chk_vld_r && (rd_data.code == code_r);
  assign more    = iss_r < count_r;
  assign full    = count_r == CW'(fclt_pkg::MAX_ENTRIES);
  assign read_ok = 32'(in_read_index) < 32'(count_r);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      fclt_pkg::S_IDLE: begin
        if (start) begin
          case (in_cmd)
            fclt_pkg::CMD_LOG:  state_nxt = fclt_pkg::S_SCAN;
            fclt_pkg::CMD_READ: state_nxt = fclt_pkg::S_RDWAIT;
            default:            state_nxt = fclt_pkg::S_DONE;
          endcase
        end
      end
      fclt_pkg::S_SCAN: begin
        if (hit) begin
          state_nxt = fclt_pkg::S_UPD;
        end else if (!more) begin
          state_nxt = fclt_pkg::S_APPEND;
        end
      end
      fclt_pkg::S_UPD:    state_nxt = fclt_pkg::S_DONE;
      fclt_pkg::S_APPEND: state_nxt = fclt_pkg::S_DONE;
      fclt_pkg::S_RDWAIT: state_nxt = fclt_pkg::S_DONE;
      fclt_pkg::S_DONE:   state_nxt = fclt_pkg::S_IDLE;
      default:            state_nxt = fclt_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    busy          = state_r != fclt_pkg::S_IDLE;
    mreq.rd_en    = 1'b0;
    mreq.rd_addr  = wrap_add(head_r, IW'(iss_r));
    mreq.wr_en    = 1'b0;
    mreq.wr_addr  = match_addr_r;
    wr_data       = rd_data;
    case (state_r)
      fclt_pkg::S_IDLE: begin
        mreq.rd_addr = wrap_add(head_r, IW'(in_read_index));
        mreq.rd_en   = start && (in_cmd == fclt_pkg::CMD_READ);
      end
      fclt_pkg::S_SCAN: begin
        mreq.rd_en = !hit && more;
      end
      fclt_pkg::S_UPD: begin
        mreq.wr_en        = 1'b1;
        wr_data.last_seen = now_r;
        if (rd_data.occurrences != fclt_pkg::OCC_MAX) begin
          wr_data.occurrences = rd_data.occurrences + 8'd1;
        end
      end
      fclt_pkg::S_APPEND: begin
        mreq.wr_en           = 1'b1;
        mreq.wr_addr         = full ? head_r : wrap_add(head_r, IW'(count_r));
        wr_data.code         = code_r;
        wr_data.severity     = sev_r;
        wr_data.occurrences  = 8'd1;
        wr_data.first_seen   = now_r;
        wr_data.last_seen    = now_r;
        wr_data.context_word = ctx_r;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    count_nxt      = count_r;
    head_nxt       = head_r;
    newest_nxt     = newest_r;
    out_valid_nxt  = 1'b0;
    cmd_nxt        = cmd_r;
    code_nxt       = code_r;
    sev_nxt        = sev_r;
    ctx_nxt        = ctx_r;
    now_nxt        = now_r;
    iss_nxt        = iss_r;
    chk_vld_nxt    = chk_vld_r;
    chk_idx_nxt    = chk_idx_r;
    match_addr_nxt = match_addr_r;
    notify_nxt     = notify_r;
    rvalid_nxt     = rvalid_r;
    rsel_nxt       = rsel_r;
    out_notify_nxt = out_notify_r;
    out_count_nxt  = out_count_r;
    out_newest_nxt = out_newest_r;
    out_rvalid_nxt = out_rvalid_r;
    out_entry_nxt  = out_entry_r;
    case (state_r)
      fclt_pkg::S_IDLE: begin
        if (accept) begin
          cmd_nxt     = in_cmd;
          code_nxt    = in_fault_code;
          sev_nxt     = in_fault_severity;
          ctx_nxt     = in_fault_context;
          now_nxt     = in_uptime_seconds;
          iss_nxt     = '0;
          chk_vld_nxt = 1'b0;
          notify_nxt  = 1'b0;
          rvalid_nxt  = (in_cmd == fclt_pkg::CMD_READ) && read_ok;
          if (in_cmd == fclt_pkg::CMD_CLEAR) begin
            count_nxt = '0;
            head_nxt  = '0;
          end
        end
      end
      fclt_pkg::S_SCAN: begin
        if (hit) begin
          match_addr_nxt = wrap_add(head_r, IW'(chk_idx_r));
          chk_vld_nxt    = 1'b0;
        end else if (more) begin
          iss_nxt     = iss_r + CW'(1);
          chk_vld_nxt = 1'b1;
          chk_idx_nxt = iss_r;
        end else begin
          chk_vld_nxt = 1'b0;
        end
      end
      fclt_pkg::S_APPEND: begin
        notify_nxt = 1'b1;
        newest_nxt = code_r;
        if (full) begin
          head_nxt = wrap_add(head_r, IW'(1));
        end else begin
          count_nxt = count_r + CW'(1);
        end
      end
      fclt_pkg::S_RDWAIT: begin
        rsel_nxt = rvalid_r ? rd_data : '0;
      end
      fclt_pkg::S_DONE: begin
        out_valid_nxt  = 1'b1;
        out_notify_nxt = notify_r;
        out_count_nxt  = 5'(count_r);
        out_newest_nxt = (count_r == '0) ? 16'd0 : newest_r;
        out_rvalid_nxt = rvalid_r && (cmd_r == fclt_pkg::CMD_READ);
        out_entry_nxt  = out_rvalid_nxt ? rsel_r : '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= fclt_pkg::S_IDLE;
      count_r     <= '0;
      head_r      <= '0;
      out_valid_r <= 1'b0;
      chk_vld_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      head_r      <= head_nxt;
      out_valid_r <= out_valid_nxt;
      chk_vld_r   <= chk_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    newest_r     <= newest_nxt;
    cmd_r        <= cmd_nxt;
    code_r       <= code_nxt;
    sev_r        <= sev_nxt;
    ctx_r        <= ctx_nxt;
    now_r        <= now_nxt;
    iss_r        <= iss_nxt;
    chk_idx_r    <= chk_idx_nxt;
    match_addr_r <= match_addr_nxt;
    notify_r     <= notify_nxt;
    rvalid_r     <= rvalid_nxt;
    rsel_r       <= rsel_nxt;
    out_notify_r <= out_notify_nxt;
    out_count_r  <= out_count_nxt;
    out_newest_r <= out_newest_nxt;
    out_rvalid_r <= out_rvalid_nxt;
    out_entry_r  <= out_entry_nxt;
  end

  assign out_valid            = out_valid_r;
  assign out_new_fault_notify = out_notify_r;
  assign out_entry_count      = out_count_r;
  assign out_newest_code      = out_newest_r;
  assign out_read_valid       = out_rvalid_r;
  assign out_read_code        = out_entry_r.code;
  assign out_read_severity    = out_entry_r.severity;
  assign out_read_occurrences = out_entry_r.occurrences;
  assign out_read_first_seen  = out_entry_r.first_seen;
  assign out_read_last_seen   = out_entry_r.last_seen;
  assign out_read_context     = out_entry_r.context_word;

  `FCLT_ASSERT_NEVER(a_count_bound, count_r > CW'(fclt_pkg::MAX_ENTRIES))
  `FCLT_ASSERT(a_strobe_after_done, out_valid |-> $past(state_r == fclt_pkg::S_DONE))
  `FCLT_ASSERT(a_accept_busy, (start && !busy) |=> busy)
  `FCLT_ASSERT_NEVER(a_no_idle_write, mreq.wr_en && (state_r == fclt_pkg::S_IDLE))

endmodule
